// ----- hdl/imuctf_pkg.sv -----
package imuctf_pkg;

    localparam int ATAN_LEN         = 24;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SQRT_STEPS       = 28;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_AW          = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW          = $clog2(FIFO_DEPTH + 1);
    localparam int REG_IDX_W        = 1;
    localparam int IN_W             = 112;
    localparam int OUT_W            = 64;

    localparam logic [16:0] ALPHA_RESET  = 17'd64225;
    localparam logic [16:0] ALPHA_ONE    = 17'd65536;
    localparam logic [23:0] GSCALE_RESET = 24'd256135;

    localparam logic signed [31:0] DEG90  = 32'sd5898240;
    localparam logic signed [31:0] DEG180 = 32'sd11796480;

    // product bound above which the gyro increment saturates at 2^40
    localparam logic [71:0] PROD_LIMIT = 72'd256000 << 40;
    localparam logic [40:0] DELTA_MAX  = 41'd1 << 40;
    // 2^54 / 125 rounded up
    localparam logic [47:0] RECIP_125  = 48'd144115188075856;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ALPHA  = 1'b0,
        REG_GSCALE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [31:0]        dt;
        logic signed [15:0] gy;
        logic signed [15:0] gx;
        logic signed [15:0] az;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
    } item_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [FIFO_LW-1:0] level;
    } fifo_stat_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_SUMSQ,
        C_SQRT,
        C_CORD_LOAD,
        C_CORD,
        C_GWAIT,
        C_BLEND,
        C_ROUND,
        C_DONE
    } core_state_t;

    typedef enum logic [2:0] {
        G_IDLE,
        G_MAG,
        G_LO,
        G_HI,
        G_CHECK,
        G_DIV,
        G_DONE
    } gyro_state_t;

    function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:    v = 32'sd2949120;
            5'd1:    v = 32'sd1740967;
            5'd2:    v = 32'sd919879;
            5'd3:    v = 32'sd466945;
            5'd4:    v = 32'sd234379;
            5'd5:    v = 32'sd117304;
            5'd6:    v = 32'sd58666;
            5'd7:    v = 32'sd29335;
            5'd8:    v = 32'sd14668;
            5'd9:    v = 32'sd7334;
            5'd10:   v = 32'sd3667;
            5'd11:   v = 32'sd1833;
            5'd12:   v = 32'sd917;
            5'd13:   v = 32'sd458;
            5'd14:   v = 32'sd229;
            5'd15:   v = 32'sd115;
            5'd16:   v = 32'sd57;
            5'd17:   v = 32'sd29;
            5'd18:   v = 32'sd14;
            5'd19:   v = 32'sd7;
            5'd20:   v = 32'sd4;
            5'd21:   v = 32'sd2;
            5'd22:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/imuctf_fifo.sv -----
module imuctf_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  imuctf_pkg::item_t       wr_item,
    input  logic                    pop,
    output imuctf_pkg::item_t       rd_item,
    output imuctf_pkg::fifo_stat_t  stat
);
    import imuctf_pkg::*;

    item_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wptr_reg;
    logic [FIFO_AW-1:0]  rptr_reg;
    logic [FIFO_LW-1:0]  level_reg;

    assign rd_item    = mem_reg[rptr_reg];
    assign stat.level = level_reg;
    assign stat.full  = (level_reg == FIFO_LW'(FIFO_DEPTH));
    assign stat.empty = (level_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/imuctf_front.sv -----
module imuctf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [imuctf_pkg::IN_W-1:0]   s_axis_tdata,
    input  imuctf_pkg::fifo_stat_t        stat,
    output logic                          push,
    output imuctf_pkg::item_t             item
);
    import imuctf_pkg::*;

    logic [31:0] last_tick_reg;
    logic [31:0] now_ms;

    assign now_ms        = s_axis_tdata[111:80];
    assign s_axis_tready = !stat.full;
    assign push          = s_axis_tvalid && s_axis_tready;

    // elapsed time wraps modulo 2^32
    assign item.ax = s_axis_tdata[15:0];
    assign item.ay = s_axis_tdata[31:16];
    assign item.az = s_axis_tdata[47:32];
    assign item.gx = s_axis_tdata[63:48];
    assign item.gy = s_axis_tdata[79:64];
    assign item.dt = now_ms - last_tick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_tick_reg <= '0;
        end
        else if (push)
        begin
            last_tick_reg <= now_ms;
        end
    end

endmodule

// ----- hdl/imuctf_gyro.sv -----
module imuctf_gyro (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] rate,
    input  logic [23:0]        gscale,
    input  logic [31:0]        dt,
    output logic signed [41:0] delta,
    output logic               done
);
    import imuctf_pkg::*;

    gyro_state_t  state_reg, state_next;
    logic         neg_reg, neg_next;
    logic [15:0]  mag_reg, mag_next;
    logic [39:0]  m_reg, m_next;
    logic [71:0]  p_reg, p_next;
    logic [46:0]  n_reg, n_next;
    logic [94:0]  sum_reg, sum_next;
    logic [40:0]  q_reg, q_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic [51:0]  part;
    logic [23:0]  op_n, op_r;
    logic [47:0]  pp;
    logic [94:0]  pp_sh;
    logic [41:0]  q_ext;

    assign done  = (state_reg == G_DONE);
    assign part  = (state_reg == G_LO) ? 52'(m_reg[19:0] * dt) : 52'(m_reg[39:20] * dt);
    assign q_ext = {1'b0, q_reg};
    assign delta = neg_reg ? -$signed(q_ext) : $signed(q_ext);

    // one 24x24 partial product of n * RECIP_125 per cycle
    assign op_n = cnt_reg[0] ? {1'b0, n_reg[46:24]} : n_reg[23:0];
    assign op_r = cnt_reg[1] ? RECIP_125[47:24] : RECIP_125[23:0];
    assign pp   = op_n * op_r;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    pp_sh = {47'd0, pp};
            2'd3:    pp_sh = {pp[46:0], 48'd0};
            default: pp_sh = {23'd0, pp, 24'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        m_reg   <= m_next;
        p_reg   <= p_next;
        n_reg   <= n_next;
        sum_reg <= sum_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        m_next     = m_reg;
        p_next     = p_reg;
        n_next     = n_reg;
        sum_next   = sum_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            G_IDLE, G_DONE:
            begin
                if (start)
                begin
                    neg_next   = rate[15];
                    mag_next   = rate[15] ? 16'(-rate) : 16'(rate);
                    state_next = G_MAG;
                end
            end
            G_MAG:
            begin
                m_next     = 40'(mag_reg * gscale);
                state_next = G_LO;
            end
            G_LO:
            begin
                p_next     = 72'(part);
                state_next = G_HI;
            end
            G_HI:
            begin
                p_next     = p_reg + {part, 20'd0};
                state_next = G_CHECK;
            end
            G_CHECK:
            begin
                sum_next = '0;
                cnt_next = '0;
                n_next   = p_reg[57:11];
                if (p_reg >= PROD_LIMIT)
                begin
                    q_next     = DELTA_MAX;
                    state_next = G_DONE;
                end
                else
                begin
                    state_next = G_DIV;
                end
            end
            G_DIV:
            begin
                // divide by 125 as n * ceil(2^54 / 125) >> 54, exact below 2^50
                sum_next = sum_reg + pp_sh;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd3)
                begin
                    q_next     = sum_next[94:54];
                    state_next = G_DONE;
                end
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/imuctf_core.sv -----
module imuctf_core #(
    parameter int CORDIC_STEPS = imuctf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  imuctf_pkg::item_t                    head,
    input  imuctf_pkg::fifo_stat_t               stat,
    output logic                                 pop,
    input  logic                                 cfg_wen,
    input  logic [imuctf_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [23:0]                          cfg_wdata,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [31:0]                   out_roll,
    output logic signed [31:0]                   out_pitch
);
    import imuctf_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    core_state_t         state_reg, state_next;
    item_t               item_reg, item_next;
    logic [16:0]         alpha_reg, alpha_next;
    logic [23:0]         gscale_reg, gscale_next;
    logic [55:0]         n_reg, n_next;
    logic [31:0]         rem_reg, rem_next;
    logic [27:0]         root_reg, root_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                axis_reg, axis_next;
    logic signed [31:0]  x_reg, x_next;
    logic signed [31:0]  y_reg, y_next;
    logic signed [31:0]  z_reg, z_next;
    logic signed [31:0]  off_reg, off_next;
    logic                skip_reg, skip_next;
    logic signed [31:0]  grav_roll_reg, grav_roll_next;
    logic signed [31:0]  grav_pitch_reg, grav_pitch_next;
    logic signed [61:0]  s_reg, s_next;
    logic signed [31:0]  roll_est_reg, roll_est_next;
    logic signed [31:0]  pitch_est_reg, pitch_est_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [31:0]  out_roll_reg, out_roll_next;
    logic signed [31:0]  out_pitch_reg, out_pitch_next;

    logic                gstart;
    logic signed [41:0]  delta_roll, delta_pitch;
    logic                done_roll, done_pitch;

    logic signed [31:0]  sq_y, sq_z;
    logic [31:0]         sumsq;
    logic [31:0]         rem_sh, sq_trial;
    logic signed [31:0]  ld_x, ld_y, ld_const;
    logic signed [31:0]  dx, dy, ang;
    logic signed [31:0]  est, acc;
    logic signed [41:0]  dsel;
    logic signed [42:0]  g_sum;
    logic signed [43:0]  diff;
    logic [16:0]         a_eff;
    logic signed [17:0]  a_s;
    logic signed [61:0]  prod;
    logic [61:0]         mag;
    logic [45:0]         rnd;
    logic signed [31:0]  sat;

    imuctf_gyro u_gyro_roll (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gstart),
        .rate   (item_reg.gx),
        .gscale (gscale_reg),
        .dt     (item_reg.dt),
        .delta  (delta_roll),
        .done   (done_roll)
    );

    imuctf_gyro u_gyro_pitch (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gstart),
        .rate   (item_reg.gy),
        .gscale (gscale_reg),
        .dt     (item_reg.dt),
        .delta  (delta_pitch),
        .done   (done_pitch)
    );

    assign out_valid = out_valid_reg;
    assign out_roll  = out_roll_reg;
    assign out_pitch = out_pitch_reg;

    // sum of squares
    assign sq_y  = item_reg.ay * item_reg.ay;
    assign sq_z  = item_reg.az * item_reg.az;
    assign sumsq = 32'(sq_y) + 32'(sq_z);

    // square root, two radicand bits a step
    assign rem_sh   = {rem_reg[29:0], n_reg[55:54]};
    assign sq_trial = {2'b00, root_reg, 2'b01};

    // CORDIC operands: roll is atan2(ay, az), pitch is atan2(-ax, root)
    assign ld_x = axis_reg ? 32'(root_reg) : (32'(item_reg.az) <<< 12);
    assign ld_y = axis_reg ? (-32'(item_reg.ax)) <<< 12 : (32'(item_reg.ay) <<< 12);
    assign ld_const = (ld_y > 0) ? DEG90 : ((ld_y < 0) ? -DEG90 : 32'sd0);

    assign dx       = y_reg >>> cnt_reg;
    assign dy       = x_reg >>> cnt_reg;
    assign ang      = atan_deg(cnt_reg);

    // blend: a*(g - acc) + acc*2^16
    assign est   = axis_reg ? pitch_est_reg : roll_est_reg;
    assign acc   = axis_reg ? grav_pitch_reg : grav_roll_reg;
    assign dsel  = axis_reg ? delta_pitch : delta_roll;
    assign g_sum = 43'(est) + 43'(dsel);
    assign diff  = 44'(g_sum) - 44'(acc);
    assign a_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign a_s   = $signed({1'b0, a_eff});
    assign prod  = diff * a_s;

    // round half away from zero, then saturate
    assign mag = s_reg[61] ? 62'(-s_reg) : 62'(s_reg);
    assign rnd = 46'((mag + 62'd32768) >> 16);
    always_comb
    begin
        if (!s_reg[61])
        begin
            sat = (rnd > 46'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(rnd[31:0]);
        end
        else
        begin
            sat = (rnd > 46'h8000_0000) ? 32'sh8000_0000 : -$signed(rnd[31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            alpha_reg     <= ALPHA_RESET;
            gscale_reg    <= GSCALE_RESET;
            roll_est_reg  <= '0;
            pitch_est_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alpha_reg     <= alpha_next;
            gscale_reg    <= gscale_next;
            roll_est_reg  <= roll_est_next;
            pitch_est_reg <= pitch_est_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        n_reg          <= n_next;
        rem_reg        <= rem_next;
        root_reg       <= root_next;
        cnt_reg        <= cnt_next;
        axis_reg       <= axis_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        z_reg          <= z_next;
        off_reg        <= off_next;
        skip_reg       <= skip_next;
        grav_roll_reg  <= grav_roll_next;
        grav_pitch_reg <= grav_pitch_next;
        s_reg          <= s_next;
        out_roll_reg   <= out_roll_next;
        out_pitch_reg  <= out_pitch_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        alpha_next      = alpha_reg;
        gscale_next     = gscale_reg;
        n_next          = n_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        cnt_next        = cnt_reg;
        axis_next       = axis_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        off_next        = off_reg;
        skip_next       = skip_reg;
        grav_roll_next  = grav_roll_reg;
        grav_pitch_next = grav_pitch_reg;
        s_next          = s_reg;
        roll_est_next   = roll_est_reg;
        pitch_est_next  = pitch_est_reg;
        out_valid_next  = out_valid_reg;
        out_roll_next   = out_roll_reg;
        out_pitch_next  = out_pitch_reg;
        pop             = 1'b0;
        gstart          = 1'b0;

        if (cfg_wen)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ALPHA:  alpha_next  = cfg_wdata[16:0];
                REG_GSCALE: gscale_next = cfg_wdata;
                default:    alpha_next  = alpha_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            C_IDLE:
            begin
                if (!stat.empty)
                begin
                    pop        = 1'b1;
                    item_next  = head;
                    state_next = C_SUMSQ;
                end
            end
            C_SUMSQ:
            begin
                gstart     = 1'b1;
                n_next     = {sumsq, 24'd0};
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = C_SQRT;
            end
            C_SQRT:
            begin
                if (rem_sh >= sq_trial)
                begin
                    rem_next  = rem_sh - sq_trial;
                    root_next = {root_reg[26:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[26:0], 1'b0};
                end
                n_next   = {n_reg[53:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    axis_next  = 1'b0;
                    state_next = C_CORD_LOAD;
                end
            end
            C_CORD_LOAD:
            begin
                // fold negative x into the right half plane, fix up by 180 degrees
                cnt_next  = '0;
                skip_next = (ld_x == 0);
                if (ld_x < 0)
                begin
                    x_next   = -ld_x;
                    y_next   = -ld_y;
                    off_next = (ld_y >= 0) ? DEG180 : -DEG180;
                end
                else
                begin
                    x_next   = ld_x;
                    y_next   = ld_y;
                    off_next = 32'sd0;
                end
                z_next     = (ld_x == 0) ? ld_const : 32'sd0;
                state_next = C_CORD;
            end
            C_CORD:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = skip_reg ? z_reg : z_reg + ang;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = skip_reg ? z_reg : z_reg - ang;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(NSTEP - 1))
                begin
                    if (!axis_reg)
                    begin
                        grav_roll_next = z_next + off_reg;
                        axis_next      = 1'b1;
                        state_next     = C_CORD_LOAD;
                    end
                    else
                    begin
                        grav_pitch_next = z_next + off_reg;
                        state_next      = C_GWAIT;
                    end
                end
            end
            C_GWAIT:
            begin
                if (done_roll && done_pitch)
                begin
                    axis_next  = 1'b0;
                    state_next = C_BLEND;
                end
            end
            C_BLEND:
            begin
                s_next     = prod + (62'(acc) <<< 16);
                state_next = C_ROUND;
            end
            C_ROUND:
            begin
                if (!axis_reg)
                begin
                    roll_est_next = sat;
                    axis_next     = 1'b1;
                    state_next    = C_BLEND;
                end
                else
                begin
                    pitch_est_next = sat;
                    state_next     = C_DONE;
                end
            end
            C_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_roll_next  = roll_est_reg;
                    out_pitch_next = pitch_est_reg;
                    state_next     = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/imu_complementary_tilt_filter.sv -----
// Items run one at a time through the 28-step square root, then the shared CORDIC for roll
// then pitch; the two gyro lanes (multiply, then a reciprocal multiply for the divide) finish
// alongside. The core takes the next item only after the last result is loaded for output.
// A four-item queue takes input while the back end works and a result waits.
// Reset (rst_n low, asynchronous) clears estimates, timestamp and queue, loads default weights.
module imu_complementary_tilt_filter #(
    parameter int CORDIC_STEPS = imuctf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, now_ms
    input  logic [imuctf_pkg::IN_W-1:0]          s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // roll_angle, pitch_angle
    output logic [imuctf_pkg::OUT_W-1:0]         m_axis_tdata,
    input  logic                                 cfg_wen,
    input  logic [imuctf_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [23:0]                          cfg_wdata
);
    import imuctf_pkg::*;

    fifo_stat_t          fstat;
    item_t               wr_item, rd_item;
    logic                push, pop;
    logic signed [31:0]  roll, pitch;

    imuctf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .stat          (fstat),
        .push          (push),
        .item          (wr_item)
    );

    imuctf_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .stat    (fstat)
    );

    imuctf_core #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (rd_item),
        .stat      (fstat),
        .pop       (pop),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_roll  (roll),
        .out_pitch (pitch)
    );

    assign m_axis_tdata = {pitch, roll};

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fstat.level <= FIFO_LW'(FIFO_DEPTH))
        else $error("queue level beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fstat.empty)
        else $error("pop from empty queue");

    a_level_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (fstat.level == $past(fstat.level) + 1'b1))
        else $error("queue level did not follow push");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result reissued right after delivery");

endmodule

// ----- verif/imu_complementary_tilt_filter_checker.sv -----
module imu_complementary_tilt_filter_checker #(
    parameter int CORDIC_STEPS = imuctf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [imuctf_pkg::IN_W-1:0]      s_axis_tdata,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [imuctf_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                             cfg_wen,
    input  logic [imuctf_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [23:0]                      cfg_wdata,
    output int                               errors,
    output int                               pending
);
    import imuctf_pkg::*;

    localparam longint ATAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    localparam longint ONE_Q16   = 65536;
    localparam longint DELTA_CAP = 64'sd1 << 40;

    typedef struct packed {
        logic signed [31:0] roll;
        logic signed [31:0] pitch;
    } angles_t;

    logic [16:0]        alpha;
    logic [23:0]        gscale;
    logic signed [31:0] roll_est;
    logic signed [31:0] pitch_est;
    logic [31:0]        last_ms;
    angles_t            angle_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bit_v;
        root  = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (n >= root + bit_v)
            begin
                n    = n - (root + bit_v);
                root = (root >> 1) + bit_v;
            end
            else
                root >>= 1;
            bit_v >>= 2;
        end
        return root;
    endfunction

    // vectoring rotation, x must be positive
    function automatic longint vector_angle(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_Q16[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_Q16[i];
            end
        end
        return z;
    endfunction

    function automatic longint angle_deg(longint y, longint x);
        if (x == 0)
            return (y > 0) ? 90 * ONE_Q16 : (y < 0) ? -90 * ONE_Q16 : 0;
        if (x > 0)
            return vector_angle(x, y);
        if (y >= 0)
            return vector_angle(-x, -y) + 180 * ONE_Q16;
        return vector_angle(-x, -y) - 180 * ONE_Q16;
    endfunction

    function automatic longint gyro_step(longint rate, logic [31:0] dt);
        logic [127:0] prod;
        longint       q;
        prod = 128'(rate < 0 ? -rate : rate) * 128'(gscale) * 128'(dt);
        prod = prod / 128'd256000;
        q = (prod > 128'(DELTA_CAP)) ? DELTA_CAP : longint'(prod);
        return (rate < 0) ? -q : q;
    endfunction

    function automatic logic signed [31:0] mix(longint gyro_path, longint acc);
        longint a;
        longint s;
        longint r;
        a = (alpha > ALPHA_ONE) ? ONE_Q16 : longint'(alpha);
        s = a * gyro_path + (ONE_Q16 - a) * acc;
        r = ((s < 0 ? -s : s) + 32768) >>> 16;
        if (s < 0)
            r = -r;
        if (r > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (r < -64'sd2147483648)
            return 32'sh80000000;
        return r[31:0];
    endfunction

    function automatic angles_t tilt_predict(logic [IN_W-1:0] d);
        longint      ax;
        longint      ay;
        longint      az;
        longint      gx;
        longint      gy;
        logic [31:0] now;
        logic [31:0] dt;
        longint      root;
        longint      grav_roll;
        longint      grav_pitch;
        angles_t     res;
        ax  = longint'($signed(d[15:0]));
        ay  = longint'($signed(d[31:16]));
        az  = longint'($signed(d[47:32]));
        gx  = longint'($signed(d[63:48]));
        gy  = longint'($signed(d[79:64]));
        now = d[111:80];
        dt  = now - last_ms;
        root = longint'(int_sqrt(longint'(ay * ay + az * az) << 24));
        grav_roll  = angle_deg(ay * 4096, az * 4096);
        grav_pitch = angle_deg(-ax * 4096, root);
        last_ms   = now;
        roll_est  = mix(longint'(roll_est) + gyro_step(gx, dt), grav_roll);
        pitch_est = mix(longint'(pitch_est) + gyro_step(gy, dt), grav_pitch);
        res.roll  = roll_est;
        res.pitch = pitch_est;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
                 $signed(want), $realtime);
        errors++;
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha     = ALPHA_RESET;
            gscale    = GSCALE_RESET;
            roll_est  = '0;
            pitch_est = '0;
            last_ms   = '0;
            angle_q.delete();
        end
        else
        begin
            angles_t want;
            if (cfg_wen)
            begin
                if (cfg_index == REG_ALPHA)
                    alpha = cfg_wdata[16:0];
                else if (cfg_index == REG_GSCALE)
                    gscale = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
                angle_q.push_back(tilt_predict(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (angle_q.size() == 0)
                begin
                    $display("unexpected result item at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    want = angle_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.roll)
                        report_mismatch("roll", m_axis_tdata[31:0], want.roll);
                    if (m_axis_tdata[63:32] !== want.pitch)
                        report_mismatch("pitch", m_axis_tdata[63:32], want.pitch);
                end
            end
        end
        pending = angle_q.size();
    end

endmodule

// ----- verif/imu_complementary_tilt_filter_tb.sv -----
module imu_complementary_tilt_filter_tb;
    import imuctf_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_wen;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [23:0]          cfg_wdata;
    int                   errors;
    int                   pending;
    int                   stall_cycles;
    int                   cycle;
    int                   sent;
    logic [31:0]          stamp;

    imu_complementary_tilt_filter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    imu_complementary_tilt_filter_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // receiver: random stalls, one long hold-off, then a stretch always ready
    initial
    begin
        m_axis_tready = 1'b0;
        cycle = 0;
        forever
        begin
            @(negedge clk);
            cycle++;
            if (cycle >= 3000 && cycle < 3400)
                m_axis_tready = 1'b0;
            else if (cycle >= 6000 && cycle < 9000)
                m_axis_tready = 1'b1;
            else
                m_axis_tready = ($urandom_range(0, 99) >= 29);
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [23:0] value);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wen   = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    // offer one item; stay on the falling edge after it is taken
    task automatic send_item(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] gx, logic [15:0] gy, logic [31:0] ms,
                             bit no_gaps);
        if (!no_gaps)
        begin
            while ($urandom_range(0, 99) < 29)
            begin
                s_axis_tvalid = 1'b0;
                @(negedge clk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {ms, gy, gx, az, ay, ax};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_random(int count);
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                ax = 16'($urandom);
                ay = 16'($urandom);
                az = 16'($urandom);
            end
            else
            begin
                // plausible gravity vectors with noise
                ax = 16'($signed($urandom_range(0, 8000)) - 4000);
                ay = 16'($signed($urandom_range(0, 8000)) - 4000);
                az = 16'($signed($urandom_range(0, 33000)) - 16500);
            end
            if ($urandom_range(0, 29) == 0)
                stamp = $urandom;
            else
                stamp = stamp + $urandom_range(0, 40);
            send_item(ax, ay, az, 16'($urandom), 16'($urandom), stamp,
                      sent >= 300 && sent < 450);
        end
        s_axis_tvalid = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wen       = 1'b0;
        cfg_index     = REG_ALPHA;
        cfg_wdata     = '0;
        stall_cycles  = 0;
        sent          = 0;
        stamp         = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: axis extremes, quadrants, zero operands, timestamp wrap
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0, 0);
        send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd10, 0);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd20, 0);
        send_item(16'h0000, 16'h1000, 16'hF000, 16'h0100, 16'hFF00, 32'd30, 0);
        send_item(16'h0000, 16'hF000, 16'hF000, 16'hFF00, 16'h0100, 32'd40, 0);
        send_item(16'h4000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 32'd50, 0);
        send_item(16'h1234, 16'h0400, 16'h0000, 16'h0001, 16'hFFFF, 32'd55, 0);
        send_item(16'h8000, 16'hFC00, 16'h0000, 16'h0000, 16'h0000, 32'd60, 0);
        send_item(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 32'd60, 0);
        send_item(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 0);
        send_item(16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 32'd5, 0);
        send_item(16'h0000, 16'h0000, 16'h3F00, 16'h0000, 16'h0000, 32'h8000_0000, 0);
        send_item(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0010, 16'hFFF0, 32'h8000_0001, 0);
        stamp = 32'h8000_0001;
        s_axis_tvalid = 1'b0;
        drain();

        // phases across the weight and scale range, extremes included
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_ALPHA, 24'd0);
                    write_reg(REG_GSCALE, 24'hFFFFFF);
                end
                1:
                begin
                    write_reg(REG_ALPHA, 24'(ALPHA_ONE));
                    write_reg(REG_GSCALE, 24'd0);
                end
                2:
                begin
                    write_reg(REG_ALPHA, 24'h1FFFF);
                    write_reg(REG_GSCALE, 24'hFFFFFF);
                end
                3:
                begin
                    write_reg(REG_ALPHA, 24'(ALPHA_RESET));
                    write_reg(REG_GSCALE, 24'(GSCALE_RESET));
                end
                default:
                begin
                    write_reg(REG_ALPHA, 24'($urandom_range(0, 131071)));
                    write_reg(REG_GSCALE, 24'($urandom));
                end
            endcase
            send_random(phase == 3 ? 260 : 90);
            drain();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/imuctf_pkg.sv
hdl/imuctf_fifo.sv
hdl/imuctf_front.sv
hdl/imuctf_gyro.sv
hdl/imuctf_core.sv
hdl/imu_complementary_tilt_filter.sv
verif/imu_complementary_tilt_filter_checker.sv
verif/imu_complementary_tilt_filter_tb.sv
